// ===== sv/assert_macros.svh =====
// Assertion helpers included by the deque core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== sv/wad_pkg.sv =====
package wad_pkg;

    localparam int DEPTH_DEF            = 64;
    localparam int DATA_WIDTH_DEF       = 32;
    localparam int CRITICAL_RESERVE_DEF = 8;

    localparam int HWM_W    = 6;
    localparam int WINDOW_W = 16;
    localparam int DROP_W   = 16;
    localparam int WORD_W   = 32;
    localparam int OCC_W    = 7;

    localparam logic [HWM_W-1:0]    HWM_RST    = 6'd48;
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd1000;

    // APB register map: index is paddr[2]
    localparam int CFG_AW = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_HIGH_WM = 1'b0;
    localparam logic [0:0] REG_WINDOW  = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD_TAIL  = 2'd0,
        OP_ADD_HEAD  = 2'd1,
        OP_TAKE_HEAD = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] data;
        logic              critical;
    } t_cmd;

    typedef struct packed {
        logic [DROP_W-1:0] drop_count;
        logic              accepted;
        logic [WORD_W-1:0] pop_data;
        logic [OCC_W-1:0]  occupancy;
    } t_result;

endpackage

// ===== sv/wad_ram.sv =====
module wad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/watermark_admission_deque_core.sv =====
// Bounded deque of message words with high-watermark admission. Each command
// (push back, push front, pop front) is taken on a cycle with i_start high; o_busy
// stays low, so a command can be issued every cycle, and its result appears with
// o_valid in the cycle after. The result is shown for that one cycle only and
// cannot be held off. It is registered to match the slot memory, whose registered
// read port delivers the popped word in the cycle after the pop is taken. Slot
// storage is not cleared by reset; only written slots are ever read. Configure
// the watermark (0x0) and counter_window (0x4) while no command is in flight.
module watermark_admission_deque_core #(
    parameter int DEPTH            = wad_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH       = wad_pkg::DATA_WIDTH_DEF,
    parameter int CRITICAL_RESERVE = wad_pkg::CRITICAL_RESERVE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  wad_pkg::t_cmd                 i_cmd,
    output logic                          o_busy,
    output logic                          o_valid,
    output wad_pkg::t_result              o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wad_pkg::CFG_AW-1:0]    paddr,
    input  logic [wad_pkg::PDATA_W-1:0]   pwdata,
    output logic [wad_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import wad_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int LW  = ((CW > 8) ? CW : 8) + 1;
    localparam int SUW = AW + 1;

    // Control state
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_fill, n_fill;
    logic [DROP_W-1:0]   r_drops, n_drops;
    logic [WINDOW_W-1:0] r_pushes, n_pushes;
    logic [HWM_W-1:0]    r_hwm;
    logic [WINDOW_W-1:0] r_window;

    // Result stage
    logic                r_out_vld;
    logic [DROP_W-1:0]   r_drop_out, n_drop_out;
    logic                r_acc, n_acc;
    logic                r_pop_ok, n_pop_ok;
    logic [OCC_W-1:0]    r_occ;

    // Slot memory access
    logic                  w_we, w_re;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata, w_rdata;
    logic [63:0]           w_word64, w_rd64;

    logic                w_take;
    logic                w_cfg_wr;
    logic [LW-1:0]       w_limit;
    logic                w_admit;
    logic [SUW-1:0]      w_sum;
    logic [AW-1:0]       w_tail, w_head_dec, w_head_inc;
    logic [WINDOW_W-1:0] w_push_inc;

    assign o_busy = 1'b0;
    assign pready = 1'b1;
    assign w_take = i_start && !o_busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Admission limit: watermark, widened by the reserve for critical words
    assign w_limit = LW'(r_hwm) + (i_cmd.critical ? LW'(CRITICAL_RESERVE) : LW'(0));
    assign w_admit = (LW'(r_fill) < w_limit) && (r_fill < CW'(DEPTH));

    // Ring arithmetic without a divider: one compare and subtract
    assign w_sum  = SUW'(r_head) + SUW'(r_fill);
    assign w_tail = (w_sum >= SUW'(DEPTH)) ? AW'(w_sum - SUW'(DEPTH)) : AW'(w_sum);
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_push_inc = r_pushes + 1'b1;

    assign w_word64 = 64'(i_cmd.data);
    assign w_wdata  = w_word64[DATA_WIDTH-1:0];

    always_comb begin
        n_head     = r_head;
        n_fill     = r_fill;
        n_drops    = r_drops;
        n_pushes   = r_pushes;
        n_drop_out = '0;
        n_acc      = 1'b0;
        n_pop_ok   = 1'b0;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_waddr    = w_tail;
        unique case (i_cmd.op)
            OP_ADD_TAIL, OP_ADD_HEAD: begin
                if (w_admit) begin
                    if (i_cmd.op == OP_ADD_HEAD) begin
                        n_head  = w_head_dec;
                        w_waddr = w_head_dec;
                    end
                    w_we   = w_take;
                    n_fill = r_fill + 1'b1;
                    n_acc  = 1'b1;
                end else begin
                    n_drops    = r_drops + 1'b1;
                    n_drop_out = r_drops + 1'b1;
                end
                // Clear both counters once the window is reached
                if (w_push_inc >= r_window) begin
                    n_drops  = '0;
                    n_pushes = '0;
                end else begin
                    n_pushes = w_push_inc;
                end
            end
            OP_TAKE_HEAD: begin
                if (r_fill != '0) begin
                    w_re     = w_take;
                    n_head   = w_head_inc;
                    n_fill   = r_fill - 1'b1;
                    n_acc    = 1'b1;
                    n_pop_ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_fill    <= '0;
            r_drops   <= '0;
            r_pushes  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_take;
            if (w_take) begin
                r_head   <= n_head;
                r_fill   <= n_fill;
                r_drops  <= n_drops;
                r_pushes <= n_pushes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_drop_out <= n_drop_out;
            r_acc      <= n_acc;
            r_pop_ok   <= n_pop_ok;
            r_occ      <= OCC_W'(n_fill);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hwm    <= HWM_RST;
            r_window <= WINDOW_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_HIGH_WM: r_hwm    <= pwdata[HWM_W-1:0];
                REG_WINDOW:  r_window <= pwdata[WINDOW_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_HIGH_WM: prdata = PDATA_W'(r_hwm);
            REG_WINDOW:  prdata = PDATA_W'(r_window);
        endcase
    end

    wad_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    // Drop the stale read word unless this result is a pop that returned a word
    assign w_rd64 = 64'(w_rdata);

    assign o_valid             = r_out_vld;
    assign o_result.drop_count = r_drop_out;
    assign o_result.accepted   = r_acc;
    assign o_result.pop_data   = r_pop_ok ? w_rd64[WORD_W-1:0] : '0;
    assign o_result.occupancy  = r_occ;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_strobe_follows_take, i_clk, i_rst_n, w_take, o_valid)
    `ASSERT_NEXT(a_no_strobe_without_take, i_clk, i_rst_n, !w_take, !o_valid)
    `ASSERT_NEXT(a_admit_grows_fill, i_clk, i_rst_n, w_take && w_we, r_fill == CW'($past(r_fill) + 1'b1))
    `ASSERT_SAME(a_drop_not_accepted, i_clk, i_rst_n, o_valid && (o_result.drop_count != '0), !o_result.accepted)
    `ASSERT_SAME(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= CW'(DEPTH))

endmodule
